// ----- hdl/tkda_pkg.sv -----
// ----------------------------------------------------------------------------
// tkda_pkg
// Types, codes and the pitch table shared by the touch key voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tkda_pkg;

    localparam int KEY_W      = 4;
    localparam int PITCH_W    = 11;
    localparam int SENSE_W    = 13;
    localparam int TABLE_KEYS = 13;
    localparam int ROWS       = 4;
    localparam int ROW_W      = 2;

    localparam logic [KEY_W-1:0] EMPTY_KEY = 4'd15;

    localparam logic EV_NOTE_ON  = 1'b0;
    localparam logic EV_NOTE_OFF = 1'b1;
    localparam logic VOICE_ONE   = 1'b0;
    localparam logic VOICE_TWO   = 1'b1;

    localparam logic CFG_OCTAVE_ROW = 1'b0;
    localparam logic CFG_PORTAMENTO = 1'b1;

    localparam logic [PITCH_W-1:0] PITCH_TABLE [ROWS][TABLE_KEYS] = '{
        '{11'd65,  11'd69,  11'd73,  11'd78,  11'd82,  11'd87,  11'd92,
          11'd98,  11'd104, 11'd110, 11'd117, 11'd123, 11'd131},
        '{11'd131, 11'd139, 11'd147, 11'd156, 11'd165, 11'd175, 11'd185,
          11'd196, 11'd208, 11'd220, 11'd233, 11'd247, 11'd262},
        '{11'd262, 11'd277, 11'd294, 11'd311, 11'd330, 11'd349, 11'd370,
          11'd392, 11'd415, 11'd440, 11'd466, 11'd494, 11'd523},
        '{11'd523, 11'd554, 11'd587, 11'd622, 11'd659, 11'd698, 11'd740,
          11'd784, 11'd831, 11'd880, 11'd932, 11'd988, 11'd1046}
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] v1_key;
        logic [KEY_W-1:0] v2_key;
        logic             last_voice;
    } voice_state_t;

    typedef struct packed {
        logic             sample_now;
        logic             sample_p1;
        logic             sample_p2;
        logic             level;
        logic             sounding;
        logic [KEY_W-1:0] key;
    } key_bits_t;

    typedef struct packed {
        logic               kind;
        logic               voice;
        logic [KEY_W-1:0]   key;
        logic [PITCH_W-1:0] pitch;
    } event_t;

    typedef struct packed {
        logic         level;
        logic         sounding;
        voice_state_t voices;
        logic         ev_valid;
        event_t       ev;
    } key_result_t;

endpackage

`default_nettype wire

// ----- hdl/tkda_key_step.sv -----
// ----------------------------------------------------------------------------
// tkda_key_step
// Shared per-key unit: debounce one key and run the voice allocation step.
// ----------------------------------------------------------------------------
`default_nettype none

module tkda_key_step (
    input  var tkda_pkg::key_bits_t    key_in,
    input  var tkda_pkg::voice_state_t voices_in,
    input  wire [tkda_pkg::ROW_W-1:0]  octave_row,
    input  wire                        portamento_on,
    output tkda_pkg::key_result_t      result
);

    logic level_new;
    logic press;
    logic release_key;

    always_comb begin
        level_new = (key_in.level & (key_in.sample_now | key_in.sample_p1 | key_in.sample_p2))
                  | (key_in.sample_now & key_in.sample_p1 & key_in.sample_p2);
        press       = level_new & ~key_in.sounding;
        release_key = ~level_new & key_in.sounding;

        result          = '0;
        result.level    = level_new;
        result.sounding = key_in.sounding;
        result.voices   = voices_in;
        result.ev.key   = key_in.key;

        if (press) begin
            result.sounding = 1'b1;
            result.ev.kind  = tkda_pkg::EV_NOTE_ON;
            result.ev.pitch = tkda_pkg::PITCH_TABLE[octave_row][key_in.key];
            if (voices_in.v1_key == tkda_pkg::EMPTY_KEY ||
                (voices_in.last_voice == tkda_pkg::VOICE_TWO &&
                 voices_in.v2_key != tkda_pkg::EMPTY_KEY)) begin
                result.voices.v1_key     = key_in.key;
                result.voices.last_voice = tkda_pkg::VOICE_ONE;
                result.ev_valid          = 1'b1;
                result.ev.voice          = tkda_pkg::VOICE_ONE;
            end else if (!portamento_on) begin
                result.voices.v2_key     = key_in.key;
                result.voices.last_voice = tkda_pkg::VOICE_TWO;
                result.ev_valid          = 1'b1;
                result.ev.voice          = tkda_pkg::VOICE_TWO;
            end
        end else if (release_key) begin
            result.sounding = 1'b0;
            result.ev.kind  = tkda_pkg::EV_NOTE_OFF;
            if (key_in.key == voices_in.v1_key) begin
                result.voices.v1_key     = tkda_pkg::EMPTY_KEY;
                result.voices.last_voice = tkda_pkg::VOICE_TWO;
                result.ev_valid          = 1'b1;
                result.ev.voice          = tkda_pkg::VOICE_ONE;
            end else if (key_in.key == voices_in.v2_key) begin
                result.voices.v2_key     = tkda_pkg::EMPTY_KEY;
                result.voices.last_voice = tkda_pkg::VOICE_ONE;
                result.ev_valid          = 1'b1;
                result.ev.voice          = tkda_pkg::VOICE_TWO;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/touch_key_debounce_two_voice_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// touch_key_debounce_two_voice_allocator_unit
// Debounces touch keys per tick and allocates two voices, emitting note events.
// ----------------------------------------------------------------------------
// channel  | dir | tdata                          | tuser       | tlast
// s_       | in  | key_sense[12:0], zero pad      | -           | -
// m_       | out | voice, key_index[3:0], pitch_hz| event_kind  | last_event
// cfg_     | in  | index 0 octave_row, 1 portamento_on (write only)
//
// A tick is accepted in ST_IDLE, each key then passes through the shared key
// unit in ST_SCAN, and ST_FLUSH sends any held event with tlast set.
// One event is held back so tlast can be attached; a full output register and a
// held event stall the key scan on a new event. s_tready is high only when idle.
// aresetn is synchronous; it clears all key state and the voices.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_key_debounce_two_voice_allocator_unit #(
    parameter int NUM_KEYS = 13
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [15:0] s_tdata,    // [12:0] key_sense, [15:13] zero
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [15:0] m_tdata,   // [0] voice, [4:1] key_index, [15:5] pitch_hz
    output logic       m_tuser,    // [0] event_kind
    output logic       m_tlast,
    input  wire        cfg_wr_en,
    input  wire        cfg_index,
    input  wire [1:0]  cfg_wdata
);

    localparam int KW = tkda_pkg::KEY_W;
    localparam int SW = tkda_pkg::SENSE_W;
    localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

    tkda_pkg::state_t       state_reg,    state_next;
    logic [SW-1:0]          sense_reg,    sense_next;
    logic [SW-1:0]          prev1_reg,    prev1_next;
    logic [SW-1:0]          prev2_reg,    prev2_next;
    logic [SW-1:0]          level_reg,    level_next;
    logic [SW-1:0]          sound_reg,    sound_next;
    tkda_pkg::voice_state_t voices_reg,   voices_next;
    logic [KW-1:0]          key_reg,      key_next;
    logic                   pend_valid_reg, pend_valid_next;
    tkda_pkg::event_t       pend_reg,     pend_next;
    logic                   out_valid_reg, out_valid_next;
    tkda_pkg::event_t       out_reg,      out_next;
    logic                   out_last_reg, out_last_next;
    logic [tkda_pkg::ROW_W-1:0] octave_reg;
    logic                   porta_reg;

    tkda_pkg::key_bits_t    key_bits;
    tkda_pkg::key_result_t  key_res;
    logic                   out_free;

    assign key_bits.sample_now = sense_reg[key_reg];
    assign key_bits.sample_p1  = prev1_reg[key_reg];
    assign key_bits.sample_p2  = prev2_reg[key_reg];
    assign key_bits.level      = level_reg[key_reg];
    assign key_bits.sounding   = sound_reg[key_reg];
    assign key_bits.key        = key_reg;

    tkda_key_step u_key_step (
        .key_in       (key_bits),
        .voices_in    (voices_reg),
        .octave_row   (octave_reg),
        .portamento_on(porta_reg),
        .result       (key_res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == tkda_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.pitch, out_reg.key, out_reg.voice};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octave_reg <= '0;
            porta_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tkda_pkg::CFG_OCTAVE_ROW: octave_reg <= cfg_wdata;
                tkda_pkg::CFG_PORTAMENTO: porta_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tkda_pkg::ST_IDLE;
            prev1_reg      <= '0;
            prev2_reg      <= '0;
            level_reg      <= '0;
            sound_reg      <= '0;
            voices_reg     <= '{v1_key: tkda_pkg::EMPTY_KEY, v2_key: tkda_pkg::EMPTY_KEY,
                                last_voice: tkda_pkg::VOICE_TWO};
            key_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev1_reg      <= prev1_next;
            prev2_reg      <= prev2_next;
            level_reg      <= level_next;
            sound_reg      <= sound_next;
            voices_reg     <= voices_next;
            key_reg        <= key_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        sense_reg    <= sense_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        sense_next      = sense_reg;
        prev1_next      = prev1_reg;
        prev2_next      = prev2_reg;
        level_next      = level_reg;
        sound_next      = sound_reg;
        voices_next     = voices_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            tkda_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    sense_next = s_tdata[SW-1:0];
                    key_next   = '0;
                    state_next = tkda_pkg::ST_SCAN;
                end
            end
            tkda_pkg::ST_SCAN: begin
                // hold while a new event would displace a held one with no room
                if (!(key_res.ev_valid && pend_valid_reg && !out_free)) begin
                    prev1_next[key_reg]  = key_bits.sample_now;
                    prev2_next[key_reg]  = key_bits.sample_p1;
                    level_next[key_reg]  = key_res.level;
                    sound_next[key_reg]  = key_res.sounding;
                    voices_next          = key_res.voices;
                    if (key_res.ev_valid) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = key_res.ev;
                    end
                    if (key_reg == LAST_KEY) begin
                        state_next = tkda_pkg::ST_FLUSH;
                    end else begin
                        key_next = key_reg + 1'b1;
                    end
                end
            end
            tkda_pkg::ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = tkda_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = tkda_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tkda_pkg::ST_IDLE;
            end
        endcase
    end

    a_idle_nothing_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("held event while accepting a new tick");

    a_voices_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (voices_reg.v1_key != tkda_pkg::EMPTY_KEY) |-> (voices_reg.v1_key != voices_reg.v2_key))
        else $error("both voices hold the same key");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tkda_pkg::ST_SCAN) |-> (key_reg <= LAST_KEY))
        else $error("key counter past last key");

    a_flush_empty_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tkda_pkg::ST_FLUSH && !pend_valid_reg) |=> (state_reg == tkda_pkg::ST_IDLE))
        else $error("flush without held event did not return to idle");

endmodule

`default_nettype wire
